FILE: rtl/fud_pkg.sv
// Package for the form body decoder: result kinds, escape phases, beat types
// and the hex digit helper. No dependencies.
`timescale 1ns / 1ps

package fud_pkg;

  localparam int unsigned MaxBodyBytesDef = 4096;
  localparam int unsigned CntW            = 12;
  localparam logic [CntW-1:0] CntMax      = '1;
  localparam logic [CntW-1:0] CfgReset    = 12'd4095;
  localparam int unsigned MaxResults      = 3;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_FIELD_END = 3'd2,
    KIND_FORM_END  = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      out_byte;
    logic [CntW-1:0] field_index;
  } result_t;

  // Results caused by one input beat, packed from slot 0 upward
  typedef struct packed {
    logic [1:0]  count;
    result_t [MaxResults-1:0] ent;
  } step_t;

  // Parser status seen at the top level
  typedef struct packed {
    logic            error_latched;
    esc_e            escape_phase;
    logic [CntW-1:0] field_number;
  } stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: rtl/fud_in_if.sv
// Input channel: one raw body byte per beat with its flags.
// Depends on nothing.
`timescale 1ns / 1ps

interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_body;

  modport source (output valid, data_byte, has_byte, end_of_body, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_body, output ready);
endinterface

FILE: rtl/fud_out_if.sv
// Output channel: one decoded result per beat.
// Depends on fud_pkg for the result kind.
`timescale 1ns / 1ps

interface fud_out_if
  import fud_pkg::*;
();
  logic            valid;
  logic            ready;
  kind_e           kind;
  logic [7:0]      out_byte;
  logic [CntW-1:0] field_index;
  logic            last_of_run;

  modport source (output valid, kind, out_byte, field_index, last_of_run, input ready);
  modport sink   (input valid, kind, out_byte, field_index, last_of_run, output ready);
endinterface

FILE: rtl/form_urlencoded_decoder_core.sv
// Top level of the form body decoder: parser plus result register bank.
// Depends on fud_pkg, fud_in_if, fud_out_if, fud_parser and fud_result_buf.
`timescale 1ns / 1ps

// Decodes a URL-encoded form body arriving one byte per input beat into
// name bytes, value bytes, field ends, a form end and at most one error per
// body, all tagged with the field index. Whenever the output keeps up, a
// beat that yields zero or one result lets the next beat in on the following
// cycle; a beat that yields more results (up to three, e.g. '&' closing the
// body) holds the input off while the three-entry result bank drains one
// result per output beat, and each output stall holds it off longer. The
// body length limit is the smaller of the written register and
// MAX_BODY_BYTES-1; write it only between bodies.
module form_urlencoded_decoder_core
  import fud_pkg::*;
#(
  parameter int unsigned MAX_BODY_BYTES = MaxBodyBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  fud_in_if.sink          in_i,
  fud_out_if.source       out_o
);

  logic  accept;
  logic  buf_ready;
  step_t step;
  stat_t stat;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  fud_parser #(
    .MAX_BODY_BYTES(MAX_BODY_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .has_byte_i    (in_i.has_byte),
    .end_of_body_i (in_i.end_of_body),
    .step_o        (step),
    .stat_o        (stat)
  );

  fud_result_buf u_result_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  // A closed body leaves no parse state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.end_of_body |=>
      !stat.error_latched && stat.escape_phase == ESC_IDLE && stat.field_number == '0)
    else $error("parse state not cleared after end of body");

  // Form end is always the final result of its input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_FORM_END |-> out_o.last_of_run)
    else $error("form end not last of run");
`endif

endmodule

FILE: rtl/fud_parser.sv
// Parser state, body length limit register and the per-beat decode logic.
// Depends on fud_pkg.
`timescale 1ns / 1ps

module fud_parser
  import fud_pkg::*;
#(
  parameter int unsigned MAX_BODY_BYTES = MaxBodyBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             end_of_body_i,
  output step_t            step_o,
  output stat_t            stat_o
);

  localparam int unsigned LimCapInt =
    (MAX_BODY_BYTES - 1 > int'(CntMax)) ? int'(CntMax) : MAX_BODY_BYTES - 1;
  localparam logic [CntW-1:0] LimCap = CntW'(LimCapInt);

  logic [CntW-1:0] cfg_q;
  logic            ivp_q, ivp_d;
  esc_e            esc_q, esc_d;
  logic [3:0]      hn_q, hn_d;
  logic            err_q, err_d;
  logic [CntW-1:0] bs_q, bs_d;
  logic [CntW-1:0] fn_q, fn_d;

  logic [CntW-1:0] limit;
  result_t         r_b, r_e1, r_e2;
  logic            bv, e1v, e2v;
  kind_e           part;
  hex_t            hx;

  assign limit = (cfg_q > LimCap) ? LimCap : cfg_q;
  assign part  = ivp_q ? KIND_VALUE : KIND_NAME;
  assign hx    = hex_digit(data_byte_i);

  // Decode one beat: at most one byte result, then up to two end results
  always_comb begin
    ivp_d = ivp_q;
    esc_d = esc_q;
    hn_d  = hn_q;
    err_d = err_q;
    bs_d  = bs_q;
    fn_d  = fn_q;
    bv    = 1'b0;
    e1v   = 1'b0;
    e2v   = 1'b0;
    r_b   = '{kind: KIND_ERROR, out_byte: 8'd0, field_index: fn_q};
    r_e1  = '{kind: KIND_ERROR, out_byte: 8'd0, field_index: fn_q};
    r_e2  = '{kind: KIND_FORM_END, out_byte: 8'd0, field_index: '0};

    if (!err_q && has_byte_i) begin
      if (bs_q >= limit) begin
        bv    = 1'b1;
        err_d = 1'b1;
      end else begin
        bs_d = (bs_q == CntMax) ? bs_q : bs_q + 1'b1;
        if (esc_q != ESC_IDLE) begin
          if (!hx.ok) begin
            bv    = 1'b1;
            err_d = 1'b1;
          end else if (esc_q == ESC_HIGH) begin
            hn_d  = hx.value;
            esc_d = ESC_LOW;
          end else begin
            bv    = 1'b1;
            r_b   = '{kind: part, out_byte: {hn_q, hx.value}, field_index: fn_q};
            esc_d = ESC_IDLE;
          end
        end else if (data_byte_i == ChPercent) begin
          esc_d = ESC_HIGH;
        end else if (data_byte_i == ChEquals) begin
          if (ivp_q) begin
            bv    = 1'b1;
            err_d = 1'b1;
          end else begin
            ivp_d = 1'b1;
          end
        end else if (data_byte_i == ChAmp) begin
          bv    = 1'b1;
          r_b   = '{kind: KIND_FIELD_END, out_byte: 8'd0, field_index: fn_q};
          fn_d  = (fn_q == CntMax) ? fn_q : fn_q + 1'b1;
          ivp_d = 1'b0;
        end else if (data_byte_i == ChPlus) begin
          bv  = 1'b1;
          r_b = '{kind: part, out_byte: ChSpace, field_index: fn_q};
        end else begin
          bv  = 1'b1;
          r_b = '{kind: part, out_byte: data_byte_i, field_index: fn_q};
        end
      end
    end

    if (end_of_body_i) begin
      if (!err_d) begin
        e1v = 1'b1;
        if (esc_d != ESC_IDLE) begin
          r_e1 = '{kind: KIND_ERROR, out_byte: 8'd0, field_index: fn_d};
        end else if (bs_d != '0) begin
          e2v  = 1'b1;
          r_e1 = '{kind: KIND_FIELD_END, out_byte: 8'd0, field_index: fn_d};
          r_e2 = '{kind: KIND_FORM_END, out_byte: 8'd0,
                   field_index: (fn_d == CntMax) ? fn_d : fn_d + 1'b1};
        end else begin
          r_e1 = '{kind: KIND_FORM_END, out_byte: 8'd0, field_index: '0};
        end
      end
      // Body closed: drop all parse state
      ivp_d = 1'b0;
      esc_d = ESC_IDLE;
      hn_d  = 4'd0;
      err_d = 1'b0;
      bs_d  = '0;
      fn_d  = '0;
    end
  end

  // Pack the results from slot 0 upward
  always_comb begin
    step_o.count = 2'(bv) + 2'(e1v) + 2'(e2v);
    if (bv) begin
      step_o.ent[0] = r_b;
      step_o.ent[1] = r_e1;
      step_o.ent[2] = r_e2;
    end else begin
      step_o.ent[0] = r_e1;
      step_o.ent[1] = r_e2;
      step_o.ent[2] = r_e2;
    end
  end

  assign stat_o = '{error_latched: err_q, escape_phase: esc_q, field_number: fn_q};

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Advance parse state on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivp_q <= 1'b0;
      esc_q <= ESC_IDLE;
      hn_q  <= 4'd0;
      err_q <= 1'b0;
      bs_q  <= '0;
      fn_q  <= '0;
    end else if (accept_i) begin
      ivp_q <= ivp_d;
      esc_q <= esc_d;
      hn_q  <= hn_d;
      err_q <= err_d;
      bs_q  <= bs_d;
      fn_q  <= fn_d;
    end
  end

endmodule

FILE: rtl/fud_result_buf.sv
// Result register bank: holds the up to three results of one input beat and
// sends them one per output beat. Depends on fud_pkg and fud_out_if.
`timescale 1ns / 1ps

module fud_result_buf
  import fud_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  step_t            step_i,
  output logic             ready_o,
  fud_out_if.source        out_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    ent_q [MaxResults];
  result_t    ent_d [MaxResults];
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && out_o.ready;
  // Take a new beat when the bank is empty or its last result leaves now
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  // Load on push, shift down on pop
  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (push_i) begin
      cnt_d = step_i.count;
      for (int i = 0; i < MaxResults; i++) begin
        ent_d[i] = step_i.ent[i];
      end
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.kind        = ent_q[0].kind;
  assign out_o.out_byte    = ent_q[0].out_byte;
  assign out_o.field_index = ent_q[0].field_index;
  assign out_o.last_of_run = (cnt_q == 2'd1);

endmodule

FILE: tb/sv/fud_result_checker.sv
// Result checker for the form body decoder: watches both channels and the
// limit register, predicts every result and compares it field by field.
// Depends on fud_pkg, fud_in_if and fud_out_if.
`timescale 1ns / 1ps

module fud_result_checker
  import fud_pkg::*;
#(
  parameter int unsigned MAX_BODY_BYTES = MaxBodyBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  fud_in_if               in_mon,
  fud_out_if              out_mon,
  output int unsigned     fail_cnt_o,
  output int unsigned     pending_o
);

  localparam int unsigned ReportCap = 40;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [CntW-1:0] idx;
    logic            last;
  } fud_res_t;

  // Expected results, oldest first
  fud_res_t pending_results[$];

  // Parser shadow state and the limit register
  logic [CntW-1:0] limit_reg;
  logic            in_value;
  esc_e            esc_state;
  logic [3:0]      hi_nib;
  logic            err_seen;
  logic [CntW-1:0] byte_cnt;
  logic [CntW-1:0] field_cnt;

  // Results of the beat being decoded
  fud_res_t    step_res[MaxResults];
  int unsigned step_n;

  task automatic report_mismatch(input string msg);
    if (fail_cnt_o < ReportCap) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_cnt_o++;
  endtask

  function automatic int hex_nibble(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c - 8'h30);
    if (c inside {[8'h61:8'h66]}) return int'(c - 8'h61) + 10;
    if (c inside {[8'h41:8'h46]}) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void add_res(kind_e k, logic [7:0] b, logic [CntW-1:0] i);
    if (step_n < MaxResults) begin
      step_res[step_n] = '{k, b, i, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void flag_error();
    err_seen = 1'b1;
    add_res(KIND_ERROR, 8'h00, field_cnt);
  endfunction

  function automatic void clear_parse();
    in_value  = 1'b0;
    esc_state = ESC_IDLE;
    hi_nib    = 4'h0;
    err_seen  = 1'b0;
    byte_cnt  = '0;
    field_cnt = '0;
  endfunction

  // Advance the shadow parser by one input beat and queue what it emits
  function automatic void decode_beat(logic [7:0] c, logic has, logic eob);
    logic [CntW-1:0] lim;
    int              hv;
    kind_e           part;
    fud_res_t        r;
    step_n = 0;
    lim = (limit_reg > MAX_BODY_BYTES - 1) ? CntW'(MAX_BODY_BYTES - 1) : limit_reg;
    part = in_value ? KIND_VALUE : KIND_NAME;

    if (!err_seen && has) begin
      if (byte_cnt >= lim) begin
        flag_error();
      end else begin
        if (byte_cnt != CntMax) byte_cnt++;
        if (esc_state != ESC_IDLE) begin
          hv = hex_nibble(c);
          if (hv < 0) begin
            flag_error();
          end else if (esc_state == ESC_HIGH) begin
            hi_nib    = hv[3:0];
            esc_state = ESC_LOW;
          end else begin
            add_res(part, {hi_nib, hv[3:0]}, field_cnt);
            esc_state = ESC_IDLE;
          end
        end else if (c == ChPercent) begin
          esc_state = ESC_HIGH;
        end else if (c == ChEquals) begin
          if (in_value) flag_error();
          else in_value = 1'b1;
        end else if (c == ChAmp) begin
          add_res(KIND_FIELD_END, 8'h00, field_cnt);
          if (field_cnt != CntMax) field_cnt++;
          in_value = 1'b0;
        end else if (c == ChPlus) begin
          add_res(part, ChSpace, field_cnt);
        end else begin
          add_res(part, c, field_cnt);
        end
      end
    end

    // Close the body: cut-off escape, normal end or empty body
    if (eob) begin
      if (!err_seen) begin
        if (esc_state != ESC_IDLE) begin
          flag_error();
        end else if (byte_cnt != '0) begin
          add_res(KIND_FIELD_END, 8'h00, field_cnt);
          add_res(KIND_FORM_END, 8'h00, (field_cnt == CntMax) ? field_cnt : field_cnt + 1'b1);
        end else begin
          add_res(KIND_FORM_END, 8'h00, '0);
        end
      end
      clear_parse();
    end

    for (int i = 0; i < step_n; i++) begin
      r      = step_res[i];
      r.last = (i == step_n - 1);
      pending_results.push_back(r);
    end
  endfunction

  // Compare one output beat with the oldest expectation
  task automatic check_result();
    fud_res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h index %0d",
                                out_mon.kind, out_mon.out_byte, out_mon.field_index));
    end else begin
      want = pending_results.pop_front();
      if (out_mon.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", out_mon.kind, want.kind));
      if (out_mon.out_byte !== want.data)
        report_mismatch($sformatf("byte %02h, want %02h", out_mon.out_byte, want.data));
      if (out_mon.field_index !== want.idx)
        report_mismatch($sformatf("index %0d, want %0d", out_mon.field_index, want.idx));
      if (out_mon.last_of_run !== want.last)
        report_mismatch($sformatf("last %b, want %b", out_mon.last_of_run, want.last));
    end
  endtask

  // Predict on input beats, check output beats, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results.delete();
      clear_parse();
      limit_reg  = CfgReset;
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_beat(in_mon.data_byte, in_mon.has_byte, in_mon.end_of_body);
      end
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      pending_o <= pending_results.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the form body decoder testbench: clock, reset, stimulus, output
// back-pressure and the verdict. Depends on fud_pkg, both channel
// interfaces, form_urlencoded_decoder_core and fud_result_checker.
`timescale 1ns / 1ps

module testbench;
  import fud_pkg::*;

  localparam int unsigned ClkPeriod  = 20;
  localparam int unsigned BodyLimit  = MaxBodyBytesDef;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned CycleLimit = 600000;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  fud_in_if  in_if ();
  fud_out_if out_if ();

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  // Stimulus control
  logic [7:0]  body_q[$];
  int unsigned beats_sent;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;
  bit          rx_hold_done;
  int unsigned stall_left;

  form_urlencoded_decoder_core #(
    .MAX_BODY_BYTES(BodyLimit)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  fud_result_checker #(
    .MAX_BODY_BYTES(BodyLimit)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Output back-pressure: one long hold-off, then random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      rx_hold_done <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done <= 1'b1;
      stall_left   <= LongHold - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 5);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Run limit
  initial begin : watchdog
    int unsigned cyc;
    for (cyc = 0; cyc < CycleLimit; cyc++) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic up;
    up = 1'($urandom_range(0, 1));
    if (nib < 4'd10) return 8'h30 + nib;
    return (up ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == ChPercent || b == ChPlus || b == ChEquals || b == ChAmp) b = 8'h5F;
    return b;
  endfunction

  // Non-hex bytes, half of them just outside the digit and letter ranges
  function automatic logic [7:0] bad_hex();
    logic [7:0] near_hex[12];
    near_hex = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67,
                 ChAmp, ChEquals, ChPlus, ChPercent, 8'h00, 8'hFF};
    return near_hex[$urandom_range(0, 11)];
  endfunction

  function automatic void add_escape();
    body_q.push_back(ChPercent);
    body_q.push_back(hex_char(4'($urandom_range(0, 15))));
    body_q.push_back(hex_char(4'($urandom_range(0, 15))));
  endfunction

  function automatic void add_token(bit noisy);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick <= 9) begin
      body_q.push_back(plain_char());
    end else if (pick <= 11) begin
      body_q.push_back(ChPlus);
    end else if (pick <= 15 || !noisy) begin
      add_escape();
    end else if (pick == 16) begin
      body_q.push_back(ChEquals);
    end else if (pick == 17) begin
      body_q.push_back(ChPercent);
      body_q.push_back(bad_hex());
    end else if (pick == 18) begin
      body_q.push_back(ChPercent);
      body_q.push_back(hex_char(4'($urandom_range(0, 15))));
      body_q.push_back(bad_hex());
    end else begin
      body_q.push_back(ChPercent);
    end
  endfunction

  // Build a body of fields; most are well formed, some carry broken parts
  function automatic void build_body();
    int unsigned n_fields;
    bit          noisy;
    body_q.delete();
    if ($urandom_range(0, 11) == 0) return;
    noisy    = ($urandom_range(0, 3) == 0);
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) body_q.push_back(ChAmp);
      repeat ($urandom_range(0, 3)) add_token(noisy);
      if ($urandom_range(0, 3) != 0) begin
        body_q.push_back(ChEquals);
        repeat ($urandom_range(0, 4)) add_token(noisy);
      end
    end
    if ($urandom_range(0, 5) == 0) body_q.push_back(ChAmp);
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [7:0] b, input logic has, input logic eob);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.has_byte    <= has;
    in_if.end_of_body <= eob;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Send body_q, ending on its last byte or on a bare end marker
  task automatic send_body(input bit bare_end, input bit with_noise);
    foreach (body_q[i]) begin
      if (with_noise && $urandom_range(0, 15) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0);
      end
      send_beat(body_q[i], 1'b1, !bare_end && (i == body_q.size() - 1));
      beats_sent++;
    end
    if (bare_end || body_q.size() == 0) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
      beats_sent++;
    end
  endtask

  task automatic run_random(input int unsigned n_beats);
    int unsigned target;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      build_body();
      send_body($urandom_range(0, 3) == 0, 1'b1);
    end
  endtask

  // Drop valid and wait until every expected result is out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CntW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = 8'h00;
    in_if.has_byte    = 1'b0;
    in_if.end_of_body = 1'b0;
    beats_sent        = 0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    rx_hold_req       = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty body, then a bare beat that must be ignored
    body_q.delete();
    send_body(1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    // Every well-formed decode path, byte extremes, '&' closing the body
    body_q = '{8'h00, ChPlus, ChPercent, 8'h34, 8'h66, ChEquals, 8'hFF,
               ChPercent, 8'h41, 8'h30, ChAmp};
    send_body(1'b0, 1'b0);
    // Second '=' in a field, then ignored bytes
    body_q = '{8'h61, ChEquals, 8'h62, ChEquals, 8'h63};
    send_body(1'b1, 1'b0);
    // Bad escape digit
    body_q = '{ChPercent, 8'h67, ChAmp};
    send_body(1'b0, 1'b0);
    // Escape cut off by the end of the body
    body_q = '{8'h78, ChPercent, 8'h34};
    send_body(1'b0, 1'b0);
    // Lone '=': empty name and value
    body_q = '{ChEquals};
    send_body(1'b0, 1'b0);

    // Zero limit: any byte is too many, an empty body still closes
    wait_drained();
    write_limit('0);
    body_q = '{8'h61};
    send_body(1'b0, 1'b0);
    body_q.delete();
    send_body(1'b1, 1'b0);

    // Body longer than a small limit
    wait_drained();
    write_limit(CntW'(3));
    body_q = '{8'h61, 8'h62, 8'h63, 8'h64};
    send_body(1'b0, 1'b0);

    // Random bodies; the receiver holds off once at the start
    wait_drained();
    write_limit(CfgReset);
    rx_hold_req <= 1'b1;
    run_random(100);

    wait_drained();
    write_limit(CntW'($urandom_range(6, 30)));
    run_random(100);

    wait_drained();
    write_limit(CntW'($urandom_range(1, 4)));
    run_random(30);

    // Last part at full rate on both sides
    wait_drained();
    write_limit(CntMax);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    run_random(70);

    wait_drained();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fud_pkg.sv
rtl/fud_in_if.sv
rtl/fud_out_if.sv
rtl/fud_parser.sv
rtl/fud_result_buf.sv
rtl/form_urlencoded_decoder_core.sv
tb/sv/fud_result_checker.sv
tb/sv/testbench.sv
